/* rtl/w3f_pkg.sv */
package w3f_pkg;

   typedef logic [23:0] pixel_type;
   typedef logic [7:0]  chan_type;
   typedef logic [2:0]  mode_type;
   typedef logic [1:0]  csr_index_type;

   typedef struct packed {
      chan_type lo;
      chan_type mid;
      chan_type hi;
   } triple_type;

   localparam mode_type MODE_PASS    = 3'd0;
   localparam mode_type MODE_GREY    = 3'd1;
   localparam mode_type MODE_GAUSS   = 3'd2;
   localparam mode_type MODE_MEDIAN  = 3'd3;
   localparam mode_type MODE_SOBEL_X = 3'd4;
   localparam mode_type MODE_SOBEL_Y = 3'd5;

   localparam csr_index_type REG_FILTER_MODE = 2'd0;
   localparam csr_index_type REG_SOBEL_X_THR = 2'd1;
   localparam csr_index_type REG_SOBEL_Y_THR = 2'd2;

   localparam chan_type SOBEL_X_THR_RESET = 8'd125;
   localparam chan_type SOBEL_Y_THR_RESET = 8'd100;

   // luma weights in thousandths
   localparam logic [9:0] GREY_COEF_B = 10'd114;
   localparam logic [9:0] GREY_COEF_R = 10'd299;
   localparam logic [9:0] GREY_COEF_G = 10'd587;

   // floor(x/1000) = (x * DIV1000_RECIP) >> DIV1000_SHIFT, exact for x < 2^18
   localparam int          DIV1000_SHIFT = 28;
   localparam logic [18:0] DIV1000_RECIP = 19'd268436;

   // floor(x/3) = (x * DIV3_RECIP) >> DIV3_SHIFT, exact for x < 1024
   localparam int         DIV3_SHIFT = 11;
   localparam logic [9:0] DIV3_RECIP = 10'd683;

   function automatic chan_type max2(input chan_type a, input chan_type b);
      return (a > b) ? a : b;
   endfunction

   function automatic chan_type min2(input chan_type a, input chan_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic chan_type med3(input chan_type a, input chan_type b, input chan_type c);
      return max2(min2(a, b), min2(max2(a, b), c));
   endfunction

   function automatic triple_type sort3(input chan_type a, input chan_type b, input chan_type c);
      triple_type t;
      t.lo  = min2(min2(a, b), c);
      t.hi  = max2(max2(a, b), c);
      t.mid = med3(a, b, c);
      return t;
   endfunction

endpackage

/* rtl/w3f_ifs.sv */
interface w3f_req_if;
   import w3f_pkg::*;
   logic      valid;
   logic      ready;
   pixel_type top_left;
   pixel_type top_middle;
   pixel_type top_right;
   pixel_type mid_left;
   pixel_type centre_pixel;
   pixel_type mid_right;
   pixel_type bottom_left;
   pixel_type bottom_middle;
   pixel_type bottom_right;
   logic      at_border;

   modport source (output valid, top_left, top_middle, top_right, mid_left, centre_pixel,
                   mid_right, bottom_left, bottom_middle, bottom_right, at_border,
                   input ready);
   modport sink (input valid, top_left, top_middle, top_right, mid_left, centre_pixel,
                 mid_right, bottom_left, bottom_middle, bottom_right, at_border,
                 output ready);
endinterface

interface w3f_rsp_if;
   import w3f_pkg::*;
   logic     valid;
   logic     ready;
   chan_type out_blue;
   chan_type out_green;
   chan_type out_red;

   modport source (output valid, out_blue, out_green, out_red, input ready);
   modport sink (input valid, out_blue, out_green, out_red, output ready);
endinterface

interface w3f_csr_if;
   import w3f_pkg::*;
   logic          valid;
   logic          ready;
   csr_index_type index;
   chan_type      data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* rtl/window_3x3_rgb_filter.sv */
// A word accepted on req_ch passes through stage registers 1, 2, 3 and 4 and shows on rsp_ch from stage 4.
// Throughput: one word per cycle; the four register stages advance together and
// hold as a whole while the output word waits to be taken.
// Reset: synchronous, active high; clears all stage valid bits and loads the
// registers with mode 0 (pass) and thresholds 125 and 100.
module window_3x3_rgb_filter (
   input logic       clock,
   input logic       reset,
   w3f_req_if.sink   req_ch,
   w3f_rsp_if.source rsp_ch,
   w3f_csr_if.sink   csr_ch
);
   import w3f_pkg::*;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   mode_type mode_ff;
   chan_type thr_x_ff;
   chan_type thr_y_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_PASS;
         thr_x_ff <= SOBEL_X_THR_RESET;
         thr_y_ff <= SOBEL_Y_THR_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            REG_FILTER_MODE: mode_ff  <= csr_ch.data[2:0];
            REG_SOBEL_X_THR: thr_x_ff <= csr_ch.data;
            REG_SOBEL_Y_THR: thr_y_ff <= csr_ch.data;
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Pipeline control: every stage advances when the output word is free
   // or being taken this cycle.
   // ------------------------------------------------------------------
   logic adv;
   logic v1_ff, v2_ff, v3_ff, v4_ff;

   assign adv          = !v4_ff || rsp_ch.ready;
   assign req_ch.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_ch.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: capture the window. The mode travels with the word.
   // ------------------------------------------------------------------
   pixel_type win_ff [9];
   logic      border1_ff;
   mode_type  mode1_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         win_ff[0]  <= req_ch.top_left;
         win_ff[1]  <= req_ch.top_middle;
         win_ff[2]  <= req_ch.top_right;
         win_ff[3]  <= req_ch.mid_left;
         win_ff[4]  <= req_ch.centre_pixel;
         win_ff[5]  <= req_ch.mid_right;
         win_ff[6]  <= req_ch.bottom_left;
         win_ff[7]  <= req_ch.bottom_middle;
         win_ff[8]  <= req_ch.bottom_right;
         border1_ff <= req_ch.at_border;
         mode1_ff   <= mode_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: sort each row, gaussian sum, sobel sums, luma products.
   // Channel c sits in bits 8c+7:8c (blue, green, red).
   // ------------------------------------------------------------------
   triple_type   row_in  [3][3];   // [channel][row]
   chan_type     gauss_in [3];
   chan_type     sob_in   [3];
   logic [17:0]  prod_b_in, prod_r_in, prod_g_in;
   logic [9:0]   gsum;

   triple_type   row_ff  [3][3];
   chan_type     gauss2_ff [3];
   chan_type     sob2_ff   [3];
   logic [17:0]  prod_b_ff, prod_r_ff, prod_g_ff;
   pixel_type    centre2_ff;
   logic         border2_ff;
   mode_type     mode2_ff;

   always_comb begin
      chan_type w [9];
      for (int c = 0; c < 3; c++) begin
         for (int k = 0; k < 9; k++) begin
            w[k] = win_ff[k][8*c +: 8];
         end
         for (int r = 0; r < 3; r++) begin
            row_in[c][r] = sort3(w[3*r], w[3*r+1], w[3*r+2]);
         end
         gsum = 10'({4'd0, w[0][7:4]}) + 10'({3'd0, w[1][7:3]}) + 10'({4'd0, w[2][7:4]})
              + 10'({3'd0, w[3][7:3]}) + 10'({2'd0, w[4][7:2]}) + 10'({3'd0, w[5][7:3]})
              + 10'({4'd0, w[6][7:4]}) + 10'({3'd0, w[7][7:3]}) + 10'({4'd0, w[8][7:4]});
         gauss_in[c] = gsum[7:0];
         // modular 8-bit arithmetic gives the truncated sum directly
         if (mode1_ff == MODE_SOBEL_X) begin
            sob_in[c] = w[6] + {w[7][6:0], 1'b0} + w[8] - w[0] - {w[1][6:0], 1'b0} - w[2];
         end else begin
            sob_in[c] = w[2] + {w[5][6:0], 1'b0} + w[8] - w[0] - {w[3][6:0], 1'b0} - w[6];
         end
      end
      prod_b_in = 18'(win_ff[4][7:0])   * 18'(GREY_COEF_B);
      prod_g_in = 18'(win_ff[4][15:8])  * 18'(GREY_COEF_G);
      prod_r_in = 18'(win_ff[4][23:16]) * 18'(GREY_COEF_R);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         row_ff     <= row_in;
         gauss2_ff  <= gauss_in;
         sob2_ff    <= sob_in;
         prod_b_ff  <= prod_b_in;
         prod_r_ff  <= prod_r_in;
         prod_g_ff  <= prod_g_in;
         centre2_ff <= win_ff[4];
         border2_ff <= border1_ff;
         mode2_ff   <= mode1_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: median partials, divide luma terms by 1000, sobel channel sum.
   // ------------------------------------------------------------------
   chan_type    maxlo_in [3], medmid_in [3], minhi_in [3];
   logic [36:0] qb_full, qr_full, qg_full;

   chan_type    maxlo_ff [3], medmid_ff [3], minhi_ff [3];
   chan_type    gauss3_ff [3];
   chan_type    qb_ff, qr_ff, qg_ff;
   logic [9:0]  sob_sum_ff;
   pixel_type   centre3_ff;
   logic        border3_ff;
   mode_type    mode3_ff;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         maxlo_in[c]  = max2(max2(row_ff[c][0].lo, row_ff[c][1].lo), row_ff[c][2].lo);
         medmid_in[c] = med3(row_ff[c][0].mid, row_ff[c][1].mid, row_ff[c][2].mid);
         minhi_in[c]  = min2(min2(row_ff[c][0].hi, row_ff[c][1].hi), row_ff[c][2].hi);
      end
      qb_full = 37'(prod_b_ff) * 37'(DIV1000_RECIP);
      qr_full = 37'(prod_r_ff) * 37'(DIV1000_RECIP);
      qg_full = 37'(prod_g_ff) * 37'(DIV1000_RECIP);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         maxlo_ff   <= maxlo_in;
         medmid_ff  <= medmid_in;
         minhi_ff   <= minhi_in;
         gauss3_ff  <= gauss2_ff;
         qb_ff      <= qb_full[DIV1000_SHIFT +: 8];
         qr_ff      <= qr_full[DIV1000_SHIFT +: 8];
         qg_ff      <= qg_full[DIV1000_SHIFT +: 8];
         sob_sum_ff <= 10'(sob2_ff[0]) + 10'(sob2_ff[1]) + 10'(sob2_ff[2]);
         centre3_ff <= centre2_ff;
         border3_ff <= border2_ff;
         mode3_ff   <= mode2_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 4: finish median, luma sum and sobel average; pick the result.
   // ------------------------------------------------------------------
   chan_type    med_fin [3];
   chan_type    grey_val;
   logic [19:0] avg_full;
   chan_type    avg;
   chan_type    thr_sel;
   chan_type    sob_val;
   chan_type    res_in [3];

   chan_type    res_ff [3];
   mode_type    mode4_ff;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         med_fin[c] = med3(maxlo_ff[c], medmid_ff[c], minhi_ff[c]);
      end
      // sum of the three floored terms stays at or below 254
      grey_val = qb_ff + qr_ff + qg_ff;
      avg_full = 20'(sob_sum_ff) * 20'(DIV3_RECIP);
      avg      = avg_full[DIV3_SHIFT +: 8];
      thr_sel  = (mode3_ff == MODE_SOBEL_X) ? thr_x_ff : thr_y_ff;
      sob_val  = (avg < thr_sel) ? 8'h00 : 8'hff;

      for (int c = 0; c < 3; c++) begin
         res_in[c] = centre3_ff[8*c +: 8];
      end
      if (mode3_ff == MODE_GREY) begin
         for (int c = 0; c < 3; c++) res_in[c] = grey_val;
      end else if (!border3_ff) begin
         case (mode3_ff)
            MODE_GAUSS:   for (int c = 0; c < 3; c++) res_in[c] = gauss3_ff[c];
            MODE_MEDIAN:  for (int c = 0; c < 3; c++) res_in[c] = med_fin[c];
            MODE_SOBEL_X,
            MODE_SOBEL_Y: for (int c = 0; c < 3; c++) res_in[c] = sob_val;
            default: ;  // pass-through, including the unused codes
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         res_ff   <= res_in;
         mode4_ff <= mode3_ff;
      end
   end

   assign rsp_ch.valid     = v4_ff;
   assign rsp_ch.out_blue  = res_ff[0];
   assign rsp_ch.out_green = res_ff[1];
   assign rsp_ch.out_red   = res_ff[2];

`ifndef NO_ASSERTIONS
   // nothing leaves the pipe in the cycle after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_ch.valid)
      else $error("response valid after reset");

   // a stalled output word blocks new input words
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.ready) |-> !req_ch.ready)
      else $error("input taken while output stalled");

   // while stalled, no stage gains or loses a word
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable({v1_ff, v2_ff, v3_ff, v4_ff}))
      else $error("pipeline valid bits moved during stall");

   // greyscale drives all three channels with one value
   a_grey_mono: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && mode4_ff == MODE_GREY) |->
         (rsp_ch.out_blue == rsp_ch.out_green && rsp_ch.out_green == rsp_ch.out_red))
      else $error("greyscale channels differ");
`endif

endmodule
